// ----- hdl/fpr_pkg.sv -----
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared constants, types and command/status bundles for the poll responder.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

  // Frame body limit: a body holds at most LineMax-1 bytes
  localparam int LineMax  = 32;
  localparam int BodyCntW = $clog2(LineMax);

  localparam int AngleW   = 20;
  localparam int MagW     = 19;   // |angle| <= 360000 < 2**19
  localparam int DigitN   = 6;    // decimal digits of 360000
  localparam int DigIdxW  = $clog2(DigitN);
  localparam int DigCntW  = $clog2(DigitN + 1);

  localparam logic signed [AngleW-1:0] AngleLimit = 20'sd360000;

  // Divide by ten: q = (x * Div10Mul) >> Div10Shift, exact for x < 2**19
  localparam int              Div10MulW  = 20;
  localparam logic [19:0]     Div10Mul   = 20'd838861;
  localparam int              Div10Shift = 23;

  // Register indexes on the config port
  localparam int            CfgAddrW    = 2;
  localparam logic [1:0]    CfgNodeId   = 2'd0;
  localparam logic [1:0]    CfgStart    = 2'd1;
  localparam logic [1:0]    CfgEnd      = 2'd2;

  // ASCII
  localparam logic [7:0] ChR     = 8'h52;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChMinus = 8'h2d;

  // Which byte the datapath puts into the output register
  typedef enum logic [2:0] {
    SEL_START,
    SEL_A,
    SEL_SP,
    SEL_ID,
    SEL_MINUS,
    SEL_DIGIT,
    SEL_END
  } byte_sel_e;

  typedef struct packed {
    logic      conv_step;  // one divide-by-ten step
    logic      emit;       // load output register
    byte_sel_e sel;
    logic      pop;        // consume one stored digit
  } dp_cmd_t;

  typedef struct packed {
    logic match;      // current beat closes a frame addressed to us
    logic conv_done;  // quotient of this step is zero
    logic neg;        // clamped angle is negative
    logic dig_last;   // one digit left in the buffer
    logic out_free;   // output register can take a beat
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/framed_poll_responder.sv -----
// ----------------------------------------------------------------------------
// framed_poll_responder
// Polled serial node: parses request frames, answers with the shaft angle.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one received byte per beat together with the current angle.
//     A frame is start byte, body, end byte; body "R <digits>" addressed to
//     node_id gets a reply. Non-frame bytes and mismatched frames are eaten.
//   Master stream: the reply, one ASCII byte per beat:
//     start 'A' ' ' id ' ' ['-'] millidegrees end, tlast on the end byte.
//   Config port: write-only, index 0 node_id, 1 start byte, 2 end byte.
//     Write only while no reply is in flight.
// Timing
//   A byte that does not close a matching frame is taken; ready stays up.
//   A matching end byte holds ready low for D divide-by-ten steps (D = number
//   of decimal digits, 1..6, one digit per cycle from the reciprocal multiply)
//   plus the reply bytes (N = 7..13), one per cycle unless the master stalls;
//   the reply beats go out through the output register after the last step.
// Reset
//   Clears the parser to hunting, drops any pending output beat and restores
//   node_id 0, start '<', end '>'.
// Stall
//   A stalled master side holds the output beat; the sequencer waits. The last
//   beat sits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_poll_responder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave: [7:0] rx_byte, [27:8] angle_millideg (signed), [31:28] zero
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  // master: [7:0] tx_byte; tlast = reply_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  fpr_pkg::dp_cmd_t  cmd;
  fpr_pkg::dp_stat_t stat;
  logic              in_acc;

  fpr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .in_acc_o  (in_acc),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  fpr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_acc_i    (in_acc),
    .rx_byte_i   (s_axis_tdata[7:0]),
    .angle_i     (s_axis_tdata[27:8]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- hdl/fpr_dp.sv -----
// ----------------------------------------------------------------------------
// fpr_dp
// Datapath: config registers, frame parser, angle to decimal conversion,
// digit buffer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fpr_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire logic [7:0]                     cfg_wdata_i,
  input  wire logic                           in_acc_i,
  input  wire logic [7:0]                     rx_byte_i,
  input  wire logic [fpr_pkg::AngleW-1:0]     angle_i,
  input  wire fpr_pkg::dp_cmd_t               cmd_i,
  output fpr_pkg::dp_stat_t                   stat_o,
  input  wire logic                           m_ready_i,
  output logic                                m_valid_o,
  output logic [7:0]                          m_data_o,
  output logic                                m_last_o
);

  localparam int CntW = fpr_pkg::BodyCntW;
  localparam int MagW = fpr_pkg::MagW;

  // config
  logic [3:0] node_id_q;
  logic [7:0] start_q, end_q;

  // parser
  logic            in_frame_q, in_frame_d;
  logic [CntW-1:0] body_cnt_q, body_cnt_d;
  logic            header_ok_q, header_ok_d;
  logic            digits_open_q, digits_open_d;
  logic [7:0]      parsed_id_q, parsed_id_d;

  logic            end_hit, body_room, is_digit;
  logic [11:0]     id_next;

  // conversion
  logic signed [fpr_pkg::AngleW-1:0] ang_s, ang_c, ang_abs;
  logic [MagW-1:0]                   work_q, work_d, quot, q10, diff;
  logic [MagW+fpr_pkg::Div10MulW-1:0] prod;
  logic                              neg_q;
  logic [3:0]                        dig_q [fpr_pkg::DigitN];
  logic [fpr_pkg::DigCntW-1:0]       dcnt_q;
  logic [fpr_pkg::DigIdxW-1:0]       rd_idx;

  // output
  logic       m_valid_q;
  logic [7:0] m_data_q, byte_nx;
  logic       m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= 4'd0;
      start_q   <= 8'd60;
      end_q     <= 8'd62;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        fpr_pkg::CfgNodeId: node_id_q <= cfg_wdata_i[3:0];
        fpr_pkg::CfgStart:  start_q   <= cfg_wdata_i;
        fpr_pkg::CfgEnd:    end_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---- frame parser ----
  assign end_hit   = (rx_byte_i == end_q);
  assign body_room = (body_cnt_q < CntW'(fpr_pkg::LineMax - 1));
  assign is_digit  = (rx_byte_i >= fpr_pkg::Ch0) && (rx_byte_i <= fpr_pkg::Ch9);
  // id*10 + digit; an ASCII digit carries its value in the low nibble
  assign id_next   = {1'b0, parsed_id_q, 3'b000} + {3'b000, parsed_id_q, 1'b0}
                   + {8'd0, rx_byte_i[3:0]};

  assign stat_o.match = in_frame_q && end_hit && (body_cnt_q >= CntW'(2))
                     && header_ok_q && (parsed_id_q == {4'd0, node_id_q});

  always_comb begin
    in_frame_d    = in_frame_q;
    body_cnt_d    = body_cnt_q;
    header_ok_d   = header_ok_q;
    digits_open_d = digits_open_q;
    parsed_id_d   = parsed_id_q;
    if (in_acc_i) begin
      if (!in_frame_q) begin
        if (rx_byte_i == start_q) begin
          in_frame_d    = 1'b1;
          body_cnt_d    = '0;
          header_ok_d   = 1'b0;
          digits_open_d = 1'b0;
          parsed_id_d   = 8'd0;
        end
      end else if (end_hit || !body_room) begin
        in_frame_d    = 1'b0;
        body_cnt_d    = '0;
        header_ok_d   = 1'b0;
        digits_open_d = 1'b0;
        parsed_id_d   = 8'd0;
      end else begin
        if (body_cnt_q == CntW'(0)) begin
          header_ok_d   = (rx_byte_i == fpr_pkg::ChR);
          digits_open_d = 1'b0;
        end else if (body_cnt_q == CntW'(1)) begin
          header_ok_d   = header_ok_q && (rx_byte_i == fpr_pkg::ChSp);
          digits_open_d = header_ok_q && (rx_byte_i == fpr_pkg::ChSp);
        end else if (digits_open_q) begin
          if (is_digit) begin
            parsed_id_d = (id_next > 12'd255) ? 8'd255 : id_next[7:0];
          end else begin
            digits_open_d = 1'b0;
          end
        end
        body_cnt_d = body_cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      body_cnt_q    <= '0;
      header_ok_q   <= 1'b0;
      digits_open_q <= 1'b0;
      parsed_id_q   <= 8'd0;
    end else begin
      in_frame_q    <= in_frame_d;
      body_cnt_q    <= body_cnt_d;
      header_ok_q   <= header_ok_d;
      digits_open_q <= digits_open_d;
      parsed_id_q   <= parsed_id_d;
    end
  end

  // ---- angle clamp and magnitude ----
  always_comb begin
    ang_s = angle_i;
    if (ang_s > fpr_pkg::AngleLimit) begin
      ang_c = fpr_pkg::AngleLimit;
    end else if (ang_s < -fpr_pkg::AngleLimit) begin
      ang_c = -fpr_pkg::AngleLimit;
    end else begin
      ang_c = ang_s;
    end
    ang_abs = ang_c[fpr_pkg::AngleW-1] ? -ang_c : ang_c;
  end

  // ---- divide by ten, one digit per step ----
  assign prod = work_q * fpr_pkg::Div10Mul;
  assign quot = MagW'(prod >> fpr_pkg::Div10Shift);
  assign q10  = (quot << 3) + (quot << 1);
  assign diff = work_q - q10;

  always_comb begin
    work_d = work_q;
    if (in_acc_i) begin
      work_d = ang_abs[MagW-1:0];
    end else if (cmd_i.conv_step) begin
      work_d = quot;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (in_acc_i) begin
      neg_q <= ang_c[fpr_pkg::AngleW-1];
    end
    if (cmd_i.conv_step) begin
      dig_q[dcnt_q[fpr_pkg::DigIdxW-1:0]] <= diff[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (in_acc_i) begin
      dcnt_q <= '0;
    end else if (cmd_i.conv_step) begin
      dcnt_q <= dcnt_q + fpr_pkg::DigCntW'(1);
    end else if (cmd_i.pop) begin
      dcnt_q <= dcnt_q - fpr_pkg::DigCntW'(1);
    end
  end

  // digits were stored least significant first; read back from the top
  assign rd_idx = fpr_pkg::DigIdxW'(dcnt_q - fpr_pkg::DigCntW'(1));

  assign stat_o.conv_done = (quot == '0);
  assign stat_o.neg       = neg_q;
  assign stat_o.dig_last  = (dcnt_q == fpr_pkg::DigCntW'(1));

  // ---- output register ----
  always_comb begin
    case (cmd_i.sel)
      fpr_pkg::SEL_START: byte_nx = start_q;
      fpr_pkg::SEL_A:     byte_nx = fpr_pkg::ChA;
      fpr_pkg::SEL_SP:    byte_nx = fpr_pkg::ChSp;
      fpr_pkg::SEL_ID:    byte_nx = fpr_pkg::Ch0 + {4'd0, node_id_q};
      fpr_pkg::SEL_MINUS: byte_nx = fpr_pkg::ChMinus;
      fpr_pkg::SEL_DIGIT: byte_nx = fpr_pkg::Ch0 + {4'd0, dig_q[rd_idx]};
      fpr_pkg::SEL_END:   byte_nx = end_q;
      default:            byte_nx = end_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_data_q <= byte_nx;
      m_last_q <= (cmd_i.sel == fpr_pkg::SEL_END);
    end
  end

  assign stat_o.out_free = !m_valid_q || m_ready_i;
  assign m_valid_o       = m_valid_q;
  assign m_data_o        = m_data_q;
  assign m_last_o        = m_last_q;

endmodule

`default_nettype wire

// ----- hdl/fpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpr_ctrl
// Sequencer: input gating, digit conversion steps and reply byte order.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  output logic               in_acc_o,
  input  wire fpr_pkg::dp_stat_t stat_i,
  output fpr_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_HDR  = 5'b00100,
    ST_DIG  = 5'b01000,
    ST_TAIL = 5'b10000
  } state_e;

  // header byte positions: start, 'A', space, id, space, then optional minus
  localparam logic [2:0] HdrStart = 3'd0;
  localparam logic [2:0] HdrA     = 3'd1;
  localparam logic [2:0] HdrSp1   = 3'd2;
  localparam logic [2:0] HdrId    = 3'd3;
  localparam logic [2:0] HdrSp2   = 3'd4;

  state_e     state_q, state_d;
  logic [2:0] hdr_q, hdr_d;

  assign s_ready_o = (state_q == ST_IDLE);
  assign in_acc_o  = s_valid_i && s_ready_o;

  always_comb begin
    state_d         = state_q;
    hdr_d           = hdr_q;
    cmd_o.conv_step = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.sel       = fpr_pkg::SEL_END;
    cmd_o.pop       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc_o && stat_i.match) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (stat_i.conv_done) begin
          state_d = ST_HDR;
          hdr_d   = HdrStart;
        end
      end
      ST_HDR: begin
        cmd_o.emit = stat_i.out_free;
        case (hdr_q)
          HdrStart: cmd_o.sel = fpr_pkg::SEL_START;
          HdrA:     cmd_o.sel = fpr_pkg::SEL_A;
          HdrSp1:   cmd_o.sel = fpr_pkg::SEL_SP;
          HdrId:    cmd_o.sel = fpr_pkg::SEL_ID;
          HdrSp2:   cmd_o.sel = fpr_pkg::SEL_SP;
          default:  cmd_o.sel = fpr_pkg::SEL_MINUS;
        endcase
        if (stat_i.out_free) begin
          if ((hdr_q == HdrSp2 && !stat_i.neg) || hdr_q > HdrSp2) begin
            state_d = ST_DIG;
          end else begin
            hdr_d = hdr_q + 3'd1;
          end
        end
      end
      ST_DIG: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = fpr_pkg::SEL_DIGIT;
        cmd_o.pop  = stat_i.out_free;
        if (stat_i.out_free && stat_i.dig_last) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = fpr_pkg::SEL_END;
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hdr_q   <= HdrStart;
    end else begin
      state_q <= state_d;
      hdr_q   <= hdr_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fpr_chk.sv -----
// ----------------------------------------------------------------------------
// fpr_chk
// Port-level checks for the poll responder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // stalled output beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed under stall");

  // no new request is taken while a reply is still mid-frame
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken during reply");

  // a finished reply cannot be followed directly by another closing beat
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
      !(m_axis_tvalid && m_axis_tlast))
    else $error("back-to-back reply ends");

  // a reply does not start straight after a request beat was taken
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) && !m_axis_tlast |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("reply started too early");

endmodule

bind framed_poll_responder fpr_chk u_fpr_chk (.*);

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression bench for framed_poll_responder.
// Sends request bytes with shaft angles over four register settings, predicts
// every reply byte in a scoreboard and compares each output beat in order.
// ----------------------------------------------------------------------------

module tb;
  import fpr_pkg::*;

  localparam int          SettleCycles = 32;      // outlasts one conversion plus a full reply
  localparam int          DrainLimit   = 20000;
  localparam int          LongHold     = 300;     // receiver hold-off, cycles
  localparam logic [7:0]  DefStart     = 8'h3c;   // '<'
  localparam logic [7:0]  DefEnd       = 8'h3e;   // '>'

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the request parser and queues the reply bytes
  // --------------------------------------------------------------------------
  class poll_board;
    typedef struct {
      logic [7:0] data;
      logic       last;
    } tx_beat_t;

    logic [3:0] node_id  = 4'd0;
    logic [7:0] start_ch = DefStart;
    logic [7:0] end_ch   = DefEnd;

    bit         in_frame;
    int         body_len;
    bit         hdr_ok;
    bit         digits_open;
    int         addr_acc;      // saturates at 255

    tx_beat_t   reply_q[$];
    int         errors;
    int         beats_seen;
    int         replies;

    function void clear_body();
      body_len    = 0;
      hdr_ok      = 1'b0;
      digits_open = 1'b0;
      addr_acc    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CfgNodeId: node_id  = val[3:0];
        CfgStart:  start_ch = val;
        CfgEnd:    end_ch   = val;
        default: ;
      endcase
    endfunction

    function void push_beat(logic [7:0] d, logic l);
      reply_q.push_back('{data: d, last: l});
    endfunction

    function void take_body(logic [7:0] b);
      int v;
      if (body_len == 0) begin
        hdr_ok      = (b == ChR);
        digits_open = 1'b0;
      end else if (body_len == 1) begin
        hdr_ok      = hdr_ok && (b == ChSp);
        digits_open = hdr_ok;
      end else if (digits_open) begin
        if (b >= Ch0 && b <= Ch9) begin
          v        = addr_acc * 10 + int'(b - Ch0);
          addr_acc = (v > 255) ? 255 : v;
        end else begin
          digits_open = 1'b0;
        end
      end
      body_len++;
    endfunction

    // reply: start 'A' ' ' id ' ' ['-'] millidegrees end
    function void queue_reply(logic signed [AngleW-1:0] ang);
      int    a;
      string txt;
      a = ang;
      if (a > int'(AngleLimit))  a = int'(AngleLimit);
      if (a < -int'(AngleLimit)) a = -int'(AngleLimit);
      push_beat(start_ch, 1'b0);
      push_beat(ChA, 1'b0);
      push_beat(ChSp, 1'b0);
      push_beat(Ch0 + {4'd0, node_id}, 1'b0);
      push_beat(ChSp, 1'b0);
      if (a < 0) begin
        push_beat(ChMinus, 1'b0);
        a = -a;
      end
      txt = $sformatf("%0d", a);
      foreach (txt[i]) push_beat(txt[i], 1'b0);
      push_beat(end_ch, 1'b1);
      replies++;
    endfunction

    // one accepted request beat
    function void note_rx(logic [7:0] b, logic signed [AngleW-1:0] ang);
      if (!in_frame) begin
        if (b == start_ch) begin
          in_frame = 1'b1;
          clear_body();
        end
        return;
      end
      if (b == end_ch) begin
        // closes the frame, also when the body is already full
        if (body_len >= 2 && hdr_ok && addr_acc == int'(node_id))
          queue_reply(ang);
        in_frame = 1'b0;
        clear_body();
      end else if (body_len < LineMax - 1) begin
        take_body(b);
      end else begin
        // body overrun: drop silently and hunt again
        in_frame = 1'b0;
        clear_body();
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // one accepted reply beat
    task check_tx(logic [7:0] d, logic l);
      tx_beat_t want;
      beats_seen++;
      if (reply_q.size() == 0) begin
        report($sformatf("reply beat %02h last=%0b with nothing expected", d, l));
        return;
      end
      want = reply_q.pop_front();
      if (d !== want.data)
        report($sformatf("tx_byte %02h, expected %02h", d, want.data));
      if (l !== want.last)
        report($sformatf("reply_last %0b, expected %0b (byte %02h)", l, want.last, d));
    endtask

    function int pending();
      return reply_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, block under test
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_addr_i    = CfgNodeId;
  logic [7:0]  cfg_wdata_i   = '0;

  always #4 clk_i = ~clk_i;

  framed_poll_responder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  poll_board board = new();

  int idle_pct;       // sender: chance of an idle cycle before a beat
  int stall_pct;      // receiver: chance of holding tready low
  int items_sent;
  bit hold_req;       // ask the receiver for one long hold-off
  bit hold_taken;
  int hold_left;

  // --------------------------------------------------------------------------
  // Receiver: checks beats at the edge, then picks next tready.
  // The long hold-off is counted here, independent of the sender.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        board.check_tx(m_axis_tdata, m_axis_tlast);
      if (hold_req && !hold_taken) begin
        hold_left  = LongHold;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [AngleW-1:0] rand_angle();
    case ($urandom_range(9))
      0: return AngleLimit;
      1: return -AngleLimit;
      2: return '0;
      3: return AngleW'($urandom());                              // any bit pattern
      4: return AngleW'($urandom_range(524287, 360001));          // clamps high
      5: return -AngleW'($urandom_range(524288, 360001));         // clamps low
      default: return AngleW'(int'($urandom_range(720000)) - 360000);
    endcase
  endfunction

  // random body byte that does not close the frame
  function automatic logic [7:0] rand_body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == board.end_ch);
    return b;
  endfunction

  // one request beat; valid stays up across back-to-back beats
  task automatic send_item(input logic [7:0] b, input logic signed [AngleW-1:0] ang);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, ang, b};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_rx(b, ang);
    items_sent++;
  endtask

  // text frame; the given angle rides on the closing byte
  task automatic send_text(input string s, input logic signed [AngleW-1:0] ang);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], (i == s.len() - 1) ? ang : rand_angle());
  endtask

  // mostly well-formed polls, plus broken frames and line noise
  task automatic send_frame();
    logic [7:0] seq[$];
    string      idtxt;
    int         kind;
    int         id;
    int         roll;
    kind = $urandom_range(99);
    seq.push_back(board.start_ch);
    if (kind < 60) begin
      seq.push_back(ChR);
      seq.push_back(ChSp);
      case ($urandom_range(9))
        0:       id = $urandom_range(999);     // often saturates
        1:       id = $urandom_range(9);
        default: id = board.node_id;
      endcase
      idtxt = $sformatf("%0d", id);
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(2, 1)) idtxt = {"0", idtxt};
      foreach (idtxt[i]) seq.push_back(idtxt[i]);
      roll = $urandom_range(9);
      if (roll == 0) begin
        // pad to around the body limit: 30/31 fit, 32/33 overrun
        repeat ($urandom_range(33, 30) - (seq.size() - 1)) seq.push_back(rand_body_byte());
      end else if (roll > 5) begin
        repeat ($urandom_range(3, 1)) seq.push_back(rand_body_byte());
      end
    end else if (kind < 72) begin
      // bad header
      seq.push_back($urandom_range(1) ? ChR : rand_body_byte());
      repeat ($urandom_range(4)) seq.push_back(rand_body_byte());
    end else if (kind < 82) begin
      // start byte again inside the frame
      seq.push_back(board.start_ch);
      seq.push_back(ChR);
      seq.push_back(ChSp);
      seq.push_back(Ch0 + {4'd0, board.node_id});
    end else if (kind < 90) begin
      // empty or one-byte body
      repeat ($urandom_range(1)) seq.push_back(ChR);
    end else begin
      // raw noise, may hit either delimiter
      seq.delete();
      repeat ($urandom_range(4, 1)) seq.push_back(8'($urandom_range(255)));
    end
    if (kind < 90) seq.push_back(board.end_ch);
    foreach (seq[i]) send_item(seq[i], rand_angle());
  endtask

  // config writes back to back; enable dropped once at the end
  task automatic apply_setting(input logic [7:0] nid, input logic [7:0] sb,
                               input logic [7:0] eb);
    logic [1:0] idx[3];
    logic [7:0] val[3];
    idx = '{CfgNodeId, CfgStart, CfgEnd};
    val = '{nid, sb, eb};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      board.set_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // block is idle once all replies are out and the sequencer settled
  task automatic wait_drained();
    int n;
    n = 0;
    while (board.pending() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] set_nid[4];
    logic [7:0] set_sb[4];
    logic [7:0] set_eb[4];
    int         set_idle[4];
    int         set_stall[4];

    // phase settings: plain, wide delimiters, equal delimiters, masked id
    set_nid   = '{8'h00, 8'h09, 8'h0f, 8'ha5};
    set_sb    = '{DefStart, 8'h00, 8'h7c, 8'hff};
    set_eb    = '{DefEnd,   8'hff, 8'h7c, 8'h00};
    set_idle  = '{0, 54, 0, 38};
    set_stall = '{0, 0, 54, 38};

    idle_pct  = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values: node 0, '<' '>'
    send_text("<R >", AngleLimit);           // no digits: id 0 answers
    send_text("<R 0>", -AngleLimit);
    send_text("<R 00>", 20'sh7ffff);         // clamps to +360000
    send_text("<R 300>", rand_angle());      // id saturates, no reply
    send_text("<<R 0>", 20'sh80000);         // start in body spoils header

    for (int p = 0; p < 4; p++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      apply_setting(set_nid[p], set_sb[p], set_eb[p]);
      idle_pct  = set_idle[p];
      stall_pct = set_stall[p];
      if (p == 2) hold_req = 1'b1;           // output backs up into the input
      while (items_sent < 28 + 52 * (p + 1)) send_frame();
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    if (board.pending() != 0)
      board.report($sformatf("%0d reply bytes never arrived", board.pending()));

    $display("covered %0d request bytes under 4 register settings with idle/stall mixes",
             items_sent);
    $display("%0d replies predicted, %0d reply beats checked, %0d mismatches",
             board.replies, board.beats_seen, board.errors);
    if (board.errors == 0) begin
      $display("framed_poll_responder regression: pass");
    end else begin
      $display("framed_poll_responder regression: fail");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #3_200_000;
    $display("timeout: %0d reply bytes still pending", board.pending());
    $display("framed_poll_responder regression: fail");
    $finish;
  end

endmodule
